### rtl/core/pinv_pkg.sv
// ----------------------------------------------------------------------------
// pinv_pkg
// shared types and constants for the factor product inverse block
// ----------------------------------------------------------------------------
package pinv_pkg;

	localparam int WORD_BITS    = 45;
	localparam int FACTOR_COUNT = 4;
	localparam int IDX_BITS     = 2;
	localparam int BIT_CNT_BITS = 6;

	localparam logic [WORD_BITS-1:0] FACTOR_RESET [FACTOR_COUNT] = '{
		45'd223092870, 45'd2756205443, 45'd907383479, 45'd4132280413
	};

	localparam logic [1:0] STATUS_OK     = 2'd0;
	localparam logic [1:0] STATUS_NO_INV = 2'd1;
	localparam logic [1:0] STATUS_BAD    = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_RED,
		ST_MUL,
		ST_GCD_INIT,
		ST_GCD,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic load;
		logic red_clr;
		logic red_step;
		logic mul_clr;
		logic mul_step;
		logic mul_end;
		logic gcd_init;
		logic gcd_step;
	} cmd_t;

	typedef struct packed {
		logic bad_mod;
		logic prod_zero;
		logic gcd_eq;
	} stat_t;

endpackage

### rtl/core/pinv_datapath.sv
// ----------------------------------------------------------------------------
// pinv_datapath
// modular reduction, double-and-add product and binary extended gcd
// ----------------------------------------------------------------------------
module pinv_datapath (
	input  logic                             clk,
	input  logic [pinv_pkg::WORD_BITS-1:0]   modulus,
	input  logic [pinv_pkg::WORD_BITS-1:0]   factor,
	input  logic [pinv_pkg::BIT_CNT_BITS-1:0] bit_sel,
	input  pinv_pkg::cmd_t                   cmd,
	output pinv_pkg::stat_t                  stat,
	output logic [pinv_pkg::WORD_BITS-1:0]   inverse_value,
	output logic [1:0]                       status
);

	localparam int W = pinv_pkg::WORD_BITS;

	logic [W-1:0] p_q, r_q, a_q, acc_q, u_q, v_q, x1_q, x2_q;
	logic [W:0]   red_t, red_n, dbl_t, dbl_n, add_t, add_n;
	logic [W:0]   hx1, hx2, s1, s2;
	logic         mbit;

	// reduction step: r = (2r + bit) mod p
	assign red_t = {r_q, factor[bit_sel]};
	assign red_n = (red_t >= {1'b0, p_q}) ? red_t - {1'b0, p_q} : red_t;

	// product step: acc = 2acc (+ a) mod p, bits of reduced factor msb first
	assign mbit  = r_q[bit_sel];
	assign dbl_t = {acc_q, 1'b0};
	assign dbl_n = (dbl_t >= {1'b0, p_q}) ? dbl_t - {1'b0, p_q} : dbl_t;
	assign add_t = dbl_n + {1'b0, a_q};
	assign add_n = (add_t >= {1'b0, p_q}) ? add_t - {1'b0, p_q} : add_t;

	// halving and subtraction mod p
	assign hx1 = x1_q[0] ? ({1'b0, x1_q} + {1'b0, p_q}) : {1'b0, x1_q};
	assign hx2 = x2_q[0] ? ({1'b0, x2_q} + {1'b0, p_q}) : {1'b0, x2_q};
	assign s1  = (x1_q >= x2_q) ? {1'b0, x1_q} - {1'b0, x2_q}
	                            : {1'b0, x1_q} + {1'b0, p_q} - {1'b0, x2_q};
	assign s2  = (x2_q >= x1_q) ? {1'b0, x2_q} - {1'b0, x1_q}
	                            : {1'b0, x2_q} + {1'b0, p_q} - {1'b0, x1_q};

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			p_q <= modulus;
			a_q <= W'(1);
		end
		if (cmd.red_clr) begin
			r_q <= '0;
		end else if (cmd.red_step) begin
			r_q <= red_n[W-1:0];
		end
		if (cmd.mul_clr) begin
			acc_q <= '0;
		end else if (cmd.mul_step) begin
			acc_q <= mbit ? add_n[W-1:0] : dbl_n[W-1:0];
		end
		// the last accumulate goes straight into the product register
		if (cmd.mul_end) begin
			a_q <= mbit ? add_n[W-1:0] : dbl_n[W-1:0];
		end
		if (cmd.gcd_init) begin
			u_q  <= a_q;
			v_q  <= p_q;
			x1_q <= W'(1);
			x2_q <= '0;
		end else if (cmd.gcd_step) begin
			if (!u_q[0]) begin
				u_q  <= u_q >> 1;
				x1_q <= hx1[W:1];
			end else if (!v_q[0]) begin
				v_q  <= v_q >> 1;
				x2_q <= hx2[W:1];
			end else if (u_q > v_q) begin
				u_q  <= u_q - v_q;
				x1_q <= s1[W-1:0];
			end else if (v_q > u_q) begin
				v_q  <= v_q - u_q;
				x2_q <= s2[W-1:0];
			end
		end
	end

	assign stat.bad_mod   = (p_q < W'(3)) || !p_q[0];
	assign stat.prod_zero = (a_q == '0);
	assign stat.gcd_eq    = (u_q == v_q);

	always_comb begin
		inverse_value = '0;
		if ((p_q < W'(3)) || !p_q[0]) begin
			status = pinv_pkg::STATUS_BAD;
		end else if (a_q == '0 || u_q != W'(1)) begin
			status = pinv_pkg::STATUS_NO_INV;
		end else begin
			status        = pinv_pkg::STATUS_OK;
			inverse_value = x1_q;
		end
	end

endmodule

### rtl/core/pinv_ctrl.sv
// ----------------------------------------------------------------------------
// pinv_ctrl
// sequencer for reduction, product and gcd phases
// ----------------------------------------------------------------------------
module pinv_ctrl (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic                              out_free,
	input  pinv_pkg::stat_t                   stat,
	output logic                              idle,
	output logic                              fin,
	output pinv_pkg::cmd_t                    cmd,
	output logic [pinv_pkg::IDX_BITS-1:0]     idx,
	output logic [pinv_pkg::BIT_CNT_BITS-1:0] bit_sel
);

	localparam logic [pinv_pkg::BIT_CNT_BITS-1:0] TOP_BIT =
		pinv_pkg::BIT_CNT_BITS'(pinv_pkg::WORD_BITS - 1);
	localparam logic [pinv_pkg::IDX_BITS-1:0] LAST_IDX =
		pinv_pkg::IDX_BITS'(pinv_pkg::FACTOR_COUNT - 1);

	pinv_pkg::state_t state_q, state_n;
	logic [pinv_pkg::IDX_BITS-1:0]     idx_q;
	logic [pinv_pkg::BIT_CNT_BITS-1:0] bit_q;
	logic last_bit;

	assign last_bit = (bit_q == '0);

	always_comb begin
		state_n = state_q;
		case (state_q)
			pinv_pkg::ST_IDLE:     if (start) state_n = pinv_pkg::ST_CHECK;
			pinv_pkg::ST_CHECK:    state_n = stat.bad_mod ? pinv_pkg::ST_FIN : pinv_pkg::ST_RED;
			pinv_pkg::ST_RED:      if (last_bit) state_n = pinv_pkg::ST_MUL;
			pinv_pkg::ST_MUL: begin
				if (last_bit) begin
					state_n = (idx_q == LAST_IDX) ? pinv_pkg::ST_GCD_INIT : pinv_pkg::ST_RED;
				end
			end
			pinv_pkg::ST_GCD_INIT: state_n = stat.prod_zero ? pinv_pkg::ST_FIN : pinv_pkg::ST_GCD;
			pinv_pkg::ST_GCD:      if (stat.gcd_eq) state_n = pinv_pkg::ST_FIN;
			pinv_pkg::ST_FIN:      if (out_free) state_n = pinv_pkg::ST_IDLE;
			default:               state_n = pinv_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd  = '0;
		idle = 1'b0;
		fin  = 1'b0;
		case (state_q)
			pinv_pkg::ST_IDLE: begin
				idle     = 1'b1;
				cmd.load = start;
			end
			pinv_pkg::ST_CHECK:    cmd.red_clr = 1'b1;
			pinv_pkg::ST_RED: begin
				cmd.red_step = 1'b1;
				cmd.mul_clr  = last_bit;
			end
			pinv_pkg::ST_MUL: begin
				// last step updates the product and clears the reduction for the next factor
				cmd.mul_step = 1'b1;
				cmd.mul_end  = last_bit;
				cmd.red_clr  = last_bit;
			end
			pinv_pkg::ST_GCD_INIT: cmd.gcd_init = 1'b1;
			pinv_pkg::ST_GCD:      cmd.gcd_step = 1'b1;
			pinv_pkg::ST_FIN:      fin = out_free;
			default:               cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pinv_pkg::ST_IDLE;
			idx_q   <= '0;
			bit_q   <= TOP_BIT;
		end else begin
			state_q <= state_n;
			if (state_q == pinv_pkg::ST_IDLE) begin
				idx_q <= '0;
				bit_q <= TOP_BIT;
			end else if (state_q == pinv_pkg::ST_RED || state_q == pinv_pkg::ST_MUL) begin
				bit_q <= last_bit ? TOP_BIT : bit_q - 1'b1;
				if (state_q == pinv_pkg::ST_MUL && last_bit) begin
					idx_q <= idx_q + 1'b1;
				end
			end
		end
	end

	assign idx     = idx_q;
	assign bit_sel = bit_q;

endmodule

### rtl/core/primorial_inverse_mod_prime.sv
// ----------------------------------------------------------------------------
// primorial_inverse_mod_prime
// inverse modulo p of the product of four configured factors
// ----------------------------------------------------------------------------
// sequence: a modulus check, then per factor a bit-serial reduction and a
// double-and-add multiply, then gcd setup, the binary gcd and a finish state;
// a bad modulus skips to finish after the check, a zero product after gcd setup
// throughput: one item at a time; a new modulus is taken once the controller
// is back in idle, while an earlier result may still wait in the output register
// reset: arst_n clears the controller and output valid and reloads the factors
// ----------------------------------------------------------------------------
module primorial_inverse_mod_prime (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write port
	input  logic        cfg_en,
	input  logic [1:0]  cfg_index,
	input  logic [44:0] cfg_data,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // [44:0] modulus, [47:45] zero
	// output stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata    // [44:0] inverse_value, [46:45] status, [47] zero
);

	localparam int W = pinv_pkg::WORD_BITS;

	// factor registers
	logic [W-1:0] factor_q [pinv_pkg::FACTOR_COUNT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < pinv_pkg::FACTOR_COUNT; i++) begin
				factor_q[i] <= pinv_pkg::FACTOR_RESET[i];
			end
		end else if (cfg_en) begin
			factor_q[cfg_index] <= cfg_data;
		end
	end

	pinv_pkg::cmd_t  cmd;
	pinv_pkg::stat_t stat;
	logic            idle, fin, start, out_free;
	logic [pinv_pkg::IDX_BITS-1:0]     idx;
	logic [pinv_pkg::BIT_CNT_BITS-1:0] bit_sel;
	logic [W-1:0]    inv;
	logic [1:0]      status;
	logic            out_valid_q;
	logic [W-1:0]    out_inv_q;
	logic [1:0]      out_status_q;

	assign s_tready = idle;
	assign start    = s_tvalid && idle;
	assign out_free = !out_valid_q || m_tready;

	pinv_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.out_free (out_free),
		.stat     (stat),
		.idle     (idle),
		.fin      (fin),
		.cmd      (cmd),
		.idx      (idx),
		.bit_sel  (bit_sel)
	);

	pinv_datapath u_dp (
		.clk           (clk),
		.modulus       (s_tdata[W-1:0]),
		.factor        (factor_q[idx]),
		.bit_sel       (bit_sel),
		.cmd           (cmd),
		.stat          (stat),
		.inverse_value (inv),
		.status        (status)
	);

	// output register, loaded when the result is final and the slot is free
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin) begin
			out_inv_q    <= inv;
			out_status_q <= status;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, out_status_q, out_inv_q};

endmodule
